### sv/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

    localparam int DATA_BITS = 32;
    localparam int CAP_BITS  = 5;

    localparam logic [CAP_BITS-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // action codes carried in s_tuser
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // status of one directory scan
    typedef struct packed {
        logic found;
        logic old_any;
        logic free_any;
    } scan_flags_t;

endpackage

`default_nettype wire

### sv/lru_key_value_cache.sv
`default_nettype none
// one request is in flight at a time and s_tready rises with m_tvalid, so the cache takes
// no new request until the result of the last one has been put out. each request walks
// every entry once to search; hits and stored puts walk them once more to rerank, one
// entry per cycle through a single key/rank compare unit and tables with one read and one
// write port.
// reset (aresetn low, synchronous) clears all valid marks, the entry count and capacity to 16.
module lru_key_value_cache #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [lkvc_pkg::CAP_BITS-1:0]    cfg_wdata,     // capacity_limit
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [63:0]                      s_tdata,       // lookup_key, store_value
    input  wire                              s_tuser,       // action
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [63:0]                      m_tdata,       // read_value, evicted_key
    output logic [1:0]                       m_tuser        // hit, evicted
);
    import lkvc_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam logic [IW-1:0]   LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CMPW-1:0] ENT_CAP  = CMPW'(ENTRIES);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_VREAD  = 3'd3;
    localparam logic [2:0] ST_RANK   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    // entry tables
    logic [KEY_BITS-1:0]  key_mem  [ENTRIES];
    logic [DATA_BITS-1:0] val_mem  [ENTRIES];
    logic [IW-1:0]        rank_mem [ENTRIES];
    logic [KEY_BITS-1:0]  key_rd_reg;
    logic [DATA_BITS-1:0] val_rd_reg;
    logic [IW-1:0]        rank_rd_reg;

    logic [2:0]           state_reg, state_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic                 iss_reg, iss_next;
    logic                 p_v_reg;
    logic [IW-1:0]        p_idx_reg;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CAP_BITS-1:0]  cap_reg;

    logic                 req_act_reg;
    logic [KEY_BITS-1:0]  req_key_reg;
    logic [DATA_BITS-1:0] req_val_reg;

    logic [IW-1:0]        tgt_reg, tgt_next;
    logic [IW-1:0]        thr_reg, thr_next;
    logic                 inc_all_reg, inc_all_next;

    logic                 res_hit_reg, res_hit_next;
    logic [DATA_BITS-1:0] res_rd_reg, res_rd_next;
    logic                 res_ev_reg, res_ev_next;
    logic [DATA_BITS-1:0] res_evk_reg, res_evk_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [63:0]          m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;

    logic                 scan_clr;
    scan_flags_t          sflags;
    logic [IW-1:0]        found_idx, found_rank, old_idx, old_rank, free_idx;
    logic [KEY_BITS-1:0]  old_key;

    logic                 key_we;
    logic                 val_we;
    logic [IW-1:0]        val_waddr;
    logic [IW-1:0]        slot_idx;
    logic                 rank_we;
    logic [IW-1:0]        rank_wdata;

    logic [CMPW-1:0]      cap_eff;
    logic                 full;
    logic                 pass_done;

    lkvc_scan #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .IW       (IW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (scan_clr),
        .in_v       (p_v_reg && (state_reg == ST_SEARCH)),
        .in_idx     (p_idx_reg),
        .in_valid   (valid_reg[p_idx_reg]),
        .in_key     (key_rd_reg),
        .in_rank    (rank_rd_reg),
        .req_key    (req_key_reg),
        .flags      (sflags),
        .found_idx  (found_idx),
        .found_rank (found_rank),
        .old_idx    (old_idx),
        .old_rank   (old_rank),
        .old_key    (old_key),
        .free_idx   (free_idx)
    );

    // capacity of zero acts as one, above the built size it is clamped
    always_comb begin
        cap_eff = CMPW'(cap_reg);
        if (cap_reg == '0) begin
            cap_eff = CMPW'(1);
        end else if (cap_eff > ENT_CAP) begin
            cap_eff = ENT_CAP;
        end
    end

    assign full      = CMPW'(count_reg) >= cap_eff;
    assign pass_done = p_v_reg && (p_idx_reg == LAST_IDX);

    // rerank: target goes to zero, other valid entries age when newer than the old target rank, or all age on an insert
    always_comb begin
        rank_we    = 1'b0;
        rank_wdata = '0;
        if (state_reg == ST_RANK && p_v_reg) begin
            if (p_idx_reg == tgt_reg) begin
                rank_we = 1'b1;
            end else if (valid_reg[p_idx_reg] && (inc_all_reg || (rank_rd_reg < thr_reg))) begin
                rank_we    = 1'b1;
                rank_wdata = IW'(rank_rd_reg + 1'b1);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        tgt_next      = tgt_reg;
        thr_next      = thr_reg;
        inc_all_next  = inc_all_reg;
        res_hit_next  = res_hit_reg;
        res_rd_next   = res_rd_reg;
        res_ev_next   = res_ev_reg;
        res_evk_next  = res_evk_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        scan_clr      = 1'b0;
        key_we        = 1'b0;
        val_we        = 1'b0;
        val_waddr     = found_idx;
        slot_idx      = free_idx;

        if (iss_reg) begin
            if (cnt_reg == LAST_IDX) begin
                iss_next = 1'b0;
            end else begin
                cnt_next = IW'(cnt_reg + 1'b1);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SEARCH;
                    cnt_next   = '0;
                    iss_next   = 1'b1;
                    scan_clr   = 1'b1;
                end
            end
            ST_SEARCH: begin
                if (pass_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_hit_next = sflags.found;
                res_rd_next  = MISS_VALUE;
                res_ev_next  = 1'b0;
                res_evk_next = '0;
                if (sflags.found) begin
                    tgt_next     = found_idx;
                    thr_next     = found_rank;
                    inc_all_next = 1'b0;
                    if (req_act_reg == ACT_GET) begin
                        state_next = ST_VREAD;
                    end else begin
                        val_we     = 1'b1;
                        state_next = ST_RANK;
                        cnt_next   = '0;
                        iss_next   = 1'b1;
                    end
                end else if (req_act_reg == ACT_PUT) begin
                    if (full && sflags.old_any) begin
                        res_ev_next          = 1'b1;
                        res_evk_next         = DATA_BITS'(old_key);
                        valid_next[old_idx]  = 1'b0;
                        if (!sflags.free_any || (old_idx < free_idx)) begin
                            slot_idx = old_idx;
                        end
                        key_we              = 1'b1;
                        val_we              = 1'b1;
                        val_waddr           = slot_idx;
                        valid_next[slot_idx] = 1'b1;
                        tgt_next            = slot_idx;
                        inc_all_next        = 1'b1;
                        state_next          = ST_RANK;
                        cnt_next            = '0;
                        iss_next            = 1'b1;
                    end else if (sflags.free_any) begin
                        key_we               = 1'b1;
                        val_we               = 1'b1;
                        val_waddr            = slot_idx;
                        valid_next[slot_idx] = 1'b1;
                        count_next           = CW'(count_reg + 1'b1);
                        tgt_next             = slot_idx;
                        inc_all_next         = 1'b1;
                        state_next           = ST_RANK;
                        cnt_next             = '0;
                        iss_next             = 1'b1;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_VREAD: begin
                res_rd_next = val_rd_reg;
                state_next  = ST_RANK;
                cnt_next    = '0;
                iss_next    = 1'b1;
            end
            ST_RANK: begin
                if (pass_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_evk_reg, res_rd_reg};
                    m_tuser_next  = {res_ev_reg, res_hit_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            iss_reg      <= 1'b0;
            p_v_reg      <= 1'b0;
            valid_reg    <= '0;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            iss_reg      <= iss_next;
            p_v_reg      <= iss_reg;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_idx_reg   <= cnt_reg;
        tgt_reg     <= tgt_next;
        thr_reg     <= thr_next;
        inc_all_reg <= inc_all_next;
        res_hit_reg <= res_hit_next;
        res_rd_reg  <= res_rd_next;
        res_ev_reg  <= res_ev_next;
        res_evk_reg <= res_evk_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (s_tvalid && s_tready) begin
            req_act_reg <= s_tuser;
            req_key_reg <= KEY_BITS'($unsigned(s_tdata[31:0]));
            req_val_reg <= s_tdata[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[slot_idx] <= req_key_reg;
        end
        key_rd_reg <= key_mem[cnt_reg];
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_waddr] <= req_val_reg;
        end
        val_rd_reg <= val_mem[found_idx];
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[p_idx_reg] <= rank_wdata;
        end
        rank_rd_reg <= rank_mem[cnt_reg];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // valid marks and count agree whenever no request is in flight
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(valid_reg) == int'(count_reg)))
        else $error("entry count differs from valid marks");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= ENTRIES)
        else $error("entry count above built size");

    // ranks of valid entries form 0 .. count-1, so the oldest holds count-1
    a_oldest_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && sflags.old_any) |->
            (int'(old_rank) == int'(count_reg) - 1))
        else $error("oldest rank does not match entry count");

    a_hit_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && sflags.found) |-> (count_reg != '0))
        else $error("hit with empty directory");

    a_accept_starts_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SEARCH))
        else $error("accepted request did not start a search");

endmodule

`default_nettype wire

### sv/lkvc_scan.sv
`default_nettype none

module lkvc_scan #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32,
    parameter int IW       = 4
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      clear,
    input  wire                      in_v,
    input  wire  [IW-1:0]            in_idx,
    input  wire                      in_valid,
    input  wire  [KEY_BITS-1:0]      in_key,
    input  wire  [IW-1:0]            in_rank,
    input  wire  [KEY_BITS-1:0]      req_key,
    output lkvc_pkg::scan_flags_t    flags,
    output logic [IW-1:0]            found_idx,
    output logic [IW-1:0]            found_rank,
    output logic [IW-1:0]            old_idx,
    output logic [IW-1:0]            old_rank,
    output logic [KEY_BITS-1:0]      old_key,
    output logic [IW-1:0]            free_idx
);
    import lkvc_pkg::*;

    scan_flags_t       flags_reg;
    logic [IW-1:0]     found_idx_reg;
    logic [IW-1:0]     found_rank_reg;
    logic [IW-1:0]     old_idx_reg;
    logic [IW-1:0]     old_rank_reg;
    logic [KEY_BITS-1:0] old_key_reg;
    logic [IW-1:0]     free_idx_reg;

    logic is_match;
    logic is_older;
    logic is_free;

    // one key compare and one rank compare per visited entry
    assign is_match = in_v && in_valid && (in_key == req_key) && !flags_reg.found;
    assign is_older = in_v && in_valid && (!flags_reg.old_any || (in_rank > old_rank_reg));
    assign is_free  = in_v && !in_valid && !flags_reg.free_any;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            flags_reg <= '0;
        end else begin
            if (is_match) flags_reg.found    <= 1'b1;
            if (is_older) flags_reg.old_any  <= 1'b1;
            if (is_free)  flags_reg.free_any <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_match) begin
            found_idx_reg  <= in_idx;
            found_rank_reg <= in_rank;
        end
        if (is_older) begin
            old_idx_reg  <= in_idx;
            old_rank_reg <= in_rank;
            old_key_reg  <= in_key;
        end
        if (is_free) begin
            free_idx_reg <= in_idx;
        end
    end

    assign flags      = flags_reg;
    assign found_idx  = found_idx_reg;
    assign found_rank = found_rank_reg;
    assign old_idx    = old_idx_reg;
    assign old_rank   = old_rank_reg;
    assign old_key    = old_key_reg;
    assign free_idx   = free_idx_reg;

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
    import lkvc_pkg::*;

    localparam int CACHE_SLOTS   = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 100;

    typedef struct packed {
        logic                 hit;
        logic [DATA_BITS-1:0] read_value;
        logic                 evicted;
        logic [DATA_BITS-1:0] evicted_key;
    } cache_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CAP_BITS-1:0]  cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;     // lookup_key, store_value
    logic                 s_tuser   = 1'b0;   // action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;            // read_value, evicted_key
    logic [1:0]           m_tuser;            // hit, evicted

    // shadow copy of the directory
    logic [DATA_BITS-1:0] slot_key   [CACHE_SLOTS];
    logic [DATA_BITS-1:0] slot_value [CACHE_SLOTS];
    logic                 slot_used  [CACHE_SLOTS];
    int                   slot_age   [CACHE_SLOTS];
    int                   used_count;
    logic [CAP_BITS-1:0]  capacity_reg;

    cache_result_t        pending_results[$];
    int                   mismatch_count;
    int                   cycle_count;
    bit                   source_idling;
    bit                   sink_idling;
    int unsigned          ready_hold;

    logic [DATA_BITS-1:0] corner_keys[5] =
        '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

    lru_key_value_cache #(
        .ENTRIES  (CACHE_SLOTS),
        .KEY_BITS (DATA_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void clear_directory();
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_used[i]  = 1'b0;
            slot_age[i]   = 0;
        end
        used_count   = 0;
        capacity_reg = CAP_RESET;
    endfunction

    // make slot s the newest; slots newer than it age by one
    function automatic void refresh_slot(input int s);
        for (int j = 0; j < CACHE_SLOTS; j++) begin
            if (slot_used[j] && j != s && slot_age[j] < slot_age[s])
                slot_age[j]++;
        end
        slot_age[s] = 0;
    endfunction

    function automatic cache_result_t predict_access(input logic act,
                                                     input logic [DATA_BITS-1:0] key,
                                                     input logic [DATA_BITS-1:0] value);
        cache_result_t r;
        int hit_slot;
        int oldest;
        int free_slot;
        int eff_cap;
        r.hit         = 1'b0;
        r.read_value  = MISS_VALUE;
        r.evicted     = 1'b0;
        r.evicted_key = '0;
        hit_slot      = -1;
        oldest        = -1;
        free_slot     = -1;
        eff_cap = (capacity_reg == 0) ? 1 :
                  ((capacity_reg > CACHE_SLOTS) ? CACHE_SLOTS : int'(capacity_reg));
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (hit_slot < 0 && slot_used[i] && slot_key[i] == key)
                hit_slot = i;
        end
        if (hit_slot >= 0) begin
            r.hit = 1'b1;
            if (act == ACT_GET)
                r.read_value = slot_value[hit_slot];
            else
                slot_value[hit_slot] = value;
            refresh_slot(hit_slot);
        end else if (act == ACT_PUT) begin
            if (used_count >= eff_cap) begin
                for (int i = 0; i < CACHE_SLOTS; i++) begin
                    if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                        oldest = i;
                end
                if (oldest >= 0) begin
                    r.evicted         = 1'b1;
                    r.evicted_key     = slot_key[oldest];
                    slot_used[oldest] = 1'b0;
                    slot_age[oldest]  = 0;
                    used_count--;
                end
            end
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            end
            if (free_slot >= 0) begin
                for (int i = 0; i < CACHE_SLOTS; i++) begin
                    if (slot_used[i])
                        slot_age[i]++;
                end
                slot_used[free_slot]  = 1'b1;
                slot_key[free_slot]   = key;
                slot_value[free_slot] = value;
                slot_age[free_slot]   = 0;
                used_count++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // result checker and sink-side stalls; a stall only counts down while a result waits
    always @(posedge aclk) begin
        cache_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                          m_tdata, m_tuser));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch($sformatf("hit got %b exp %b", m_tuser[0], want.hit));
                if (m_tdata[31:0] !== want.read_value)
                    report_mismatch($sformatf("read_value got %h exp %h",
                                              m_tdata[31:0], want.read_value));
                if (m_tuser[1] !== want.evicted)
                    report_mismatch($sformatf("evicted got %b exp %b",
                                              m_tuser[1], want.evicted));
                if (m_tdata[63:32] !== want.evicted_key)
                    report_mismatch($sformatf("evicted_key got %h exp %h",
                                              m_tdata[63:32], want.evicted_key));
            end
            ready_hold = sink_idling ? $urandom_range(0, 3) : 0;
        end else if (m_tvalid && ready_hold > 0) begin
            ready_hold--;
        end
        m_tready <= (ready_hold == 0);
    end

    task automatic send_request(input logic act, input logic [DATA_BITS-1:0] key,
                                input logic [DATA_BITS-1:0] value);
        int unsigned gap;
        gap = source_idling ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {value, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_access(act, key, value));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        capacity_reg  = cap;
    endtask

    task automatic test_extreme_keys();
        source_idling = 1'b1;
        sink_idling   = 1'b1;
        send_request(ACT_GET, 32'h0000_0000, 32'h1234_5678);   // empty cache
        send_request(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(ACT_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_GET, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_request(ACT_GET, 32'h0000_0000, 32'h5A5A_5A5A);
        send_request(ACT_PUT, 32'hFFFF_FFFF, 32'hDEAD_BEEF);   // overwrite
        send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(ACT_GET, 32'h1234_5678, 32'h0000_0000);
    endtask

    task automatic test_capacity_below_count();
        // four entries live; zero acts as one, so each new key evicts exactly one
        set_capacity(5'd0);
        send_request(ACT_PUT, 32'h0000_0055, 32'h0000_0001);
        send_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_PUT, 32'h0000_0066, 32'h0000_0002);
        send_request(ACT_PUT, 32'h0000_0066, 32'h0000_0003);
        set_capacity(5'd1);
        send_request(ACT_PUT, 32'h0000_0077, 32'h0000_0004);
        send_request(ACT_GET, 32'h0000_0077, 32'h0000_0000);
        send_request(ACT_GET, 32'h0000_0066, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(input logic [CAP_BITS-1:0] cap, input int n_items);
        logic [DATA_BITS-1:0] key_pool[$];
        logic [DATA_BITS-1:0] key;
        int                   eff_cap;
        int                   pool_size;
        int unsigned          pick;
        set_capacity(cap);
        eff_cap   = (cap == 0) ? 1 : ((cap > CACHE_SLOTS) ? CACHE_SLOTS : int'(cap));
        pool_size = eff_cap + $urandom_range(1, 6);
        repeat (pool_size) key_pool.push_back($urandom);
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) begin
                source_idling = ($urandom_range(0, 3) != 0);
                sink_idling   = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                key = $urandom;
            else if (pick < 13)
                key = corner_keys[$urandom_range(0, 4)];
            else
                key = key_pool[$urandom_range(0, pool_size - 1)];
            send_request($urandom_range(0, 1) ? ACT_PUT : ACT_GET, key, $urandom);
        end
    endtask

    initial begin
        logic [CAP_BITS-1:0] phase_caps[10];
        source_idling  = 1'b1;
        sink_idling    = 1'b1;
        clear_directory();
        phase_caps = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd17, 5'd2, 5'd8, 5'd5,
                       5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_keys();
        test_capacity_below_count();
        for (int p = 0; p < 10; p++)
            test_random_traffic(phase_caps[p], 182);

        wait_idle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### lru_key_value_cache.f
sv/lkvc_pkg.sv
sv/lkvc_scan.sv
sv/lru_key_value_cache.sv
dv/tb_top.sv
